// ===== src/rcpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_pkg
// Shared widths, the per-stage item record and rotation helpers for the
// rotation class pair classifier.
// ----------------------------------------------------------------------------
package rcpc_pkg;

  localparam int WORD_BITS   = 21;
  localparam int SIG_SHIFTS  = 10;
  localparam int FOLD_BITS   = 7;
  localparam int WEIGHT_BITS = 5;
  localparam int CELL_COUNT  = WORD_BITS - 1;
  localparam int LATENCY     = WORD_BITS + 1;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [FOLD_BITS-1:0]   fold_t;
  typedef logic [SIG_SHIFTS-1:0]  sig_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;

  typedef struct packed {
    word_t   word_l;
    word_t   word_r;
    word_t   best_l;
    word_t   best_r;
    fold_t   fold_l;
    fold_t   fold_r;
    fold_t   fbest_l;
    fold_t   fbest_r;
    weight_t weight;
    sig_t    sig_l;
    sig_t    sig_r;
  } stage_t;

  function automatic word_t rot_word(word_t w, int k);
    return (w << k) | (w >> (WORD_BITS - k));
  endfunction

  function automatic fold_t rot_fold(fold_t w, int k);
    return (w << k) | (w >> (FOLD_BITS - k));
  endfunction

  function automatic fold_t fold_word(word_t w);
    fold_t f;
    for (int r = 0; r < FOLD_BITS; r++) begin
      f[r] = w[r] ^ w[r + FOLD_BITS] ^ w[r + 2 * FOLD_BITS];
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== src/rcpc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_cell
// One link of the rotation chain: tries rotation by SHIFT against the running
// minimum, adds a weight bit and, for SHIFT up to SIG_SHIFTS, a signature bit.
// ----------------------------------------------------------------------------
module rcpc_cell #(
  parameter int SHIFT      = 1,
  parameter int SIG_SHIFTS = rcpc_pkg::SIG_SHIFTS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            valid_i,
  input  wire rcpc_pkg::stage_t d_i,
  output logic                 valid_o,
  output rcpc_pkg::stage_t     d_o
);

  localparam int  FOLD_SHIFT = SHIFT % rcpc_pkg::FOLD_BITS;
  localparam bit  HAS_SIG    = (SHIFT <= SIG_SHIFTS);
  localparam int  SIG_IDX    = HAS_SIG ? SHIFT - 1 : 0;

  rcpc_pkg::stage_t d_nxt;
  rcpc_pkg::stage_t d_r;
  logic             valid_r;
  rcpc_pkg::word_t  rot_l;
  rcpc_pkg::word_t  rot_r;
  rcpc_pkg::fold_t  frot_l;
  rcpc_pkg::fold_t  frot_r;

  always_comb begin
    rot_l  = rcpc_pkg::rot_word(d_i.word_l, SHIFT);
    rot_r  = rcpc_pkg::rot_word(d_i.word_r, SHIFT);
    frot_l = rcpc_pkg::rot_fold(d_i.fold_l, FOLD_SHIFT);
    frot_r = rcpc_pkg::rot_fold(d_i.fold_r, FOLD_SHIFT);
    d_nxt  = d_i;
    if (rot_l < d_i.best_l) begin
      d_nxt.best_l = rot_l;
    end
    if (rot_r < d_i.best_r) begin
      d_nxt.best_r = rot_r;
    end
    if (frot_l < d_i.fbest_l) begin
      d_nxt.fbest_l = frot_l;
    end
    if (frot_r < d_i.fbest_r) begin
      d_nxt.fbest_r = frot_r;
    end
    d_nxt.weight = d_i.weight + rcpc_pkg::WEIGHT_BITS'(d_i.word_l[SHIFT]);
    if (HAS_SIG) begin
      d_nxt.sig_l[SIG_IDX] = ^(d_i.word_l & rot_l);
      d_nxt.sig_r[SIG_IDX] = ^(d_i.word_r & rot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;

endmodule
`default_nettype wire

// ===== src/rotation_class_pair_classifier.sv =====
`default_nettype none
// Path: an accepted item passes one capture stage, twenty rotation cells and one
// output register before its result is strobed.
// Throughput: one item per cycle; busy stays low and a new item may enter
// every cycle. Results cannot be stalled by the receiver.
// Reset: synchronous, active low; clears all valid bits, in-flight items drop.
// ----------------------------------------------------------------------------
// rotation_class_pair_classifier
// Canonical rotation, folded rotation and autocorrelation parity signature of
// a pair of words and the left word's weight, through a chain of rotation cells.
// ----------------------------------------------------------------------------
module rotation_class_pair_classifier #(
  parameter int SIG_SHIFTS = rcpc_pkg::SIG_SHIFTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [20:0]                in_left_word,
  input  wire logic [20:0]                in_right_word,
  output logic                            out_strobe,
  output logic                            out_compatible,
  output logic [20:0]                     out_canonical_left,
  output logic [20:0]                     out_canonical_right,
  output logic [6:0]                      out_folded_left,
  output logic [6:0]                      out_folded_right,
  output logic [4:0]                      out_left_ones,
  output logic [9:0]                      out_left_signature,
  output logic [9:0]                      out_right_signature
);

  localparam int N = rcpc_pkg::CELL_COUNT;

  rcpc_pkg::stage_t s0_nxt;
  rcpc_pkg::stage_t s0_r;
  logic             s0_valid_r;
  rcpc_pkg::stage_t chain_d [0:N];
  logic             chain_v [0:N];
  rcpc_pkg::stage_t last_d;
  logic             out_strobe_r;
  logic             out_compatible_r;
  rcpc_pkg::word_t  out_canonical_left_r;
  rcpc_pkg::word_t  out_canonical_right_r;
  rcpc_pkg::fold_t  out_folded_left_r;
  rcpc_pkg::fold_t  out_folded_right_r;
  rcpc_pkg::weight_t out_left_ones_r;
  rcpc_pkg::sig_t   out_left_signature_r;
  rcpc_pkg::sig_t   out_right_signature_r;

  assign busy = 1'b0;

  always_comb begin
    s0_nxt         = '0;
    s0_nxt.word_l  = in_left_word;
    s0_nxt.word_r  = in_right_word;
    s0_nxt.best_l  = in_left_word;
    s0_nxt.best_r  = in_right_word;
    s0_nxt.fold_l  = rcpc_pkg::fold_word(in_left_word);
    s0_nxt.fold_r  = rcpc_pkg::fold_word(in_right_word);
    s0_nxt.fbest_l = s0_nxt.fold_l;
    s0_nxt.fbest_r = s0_nxt.fold_r;
    s0_nxt.weight  = rcpc_pkg::WEIGHT_BITS'(in_left_word[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
  end

  assign chain_d[0] = s0_r;
  assign chain_v[0] = s0_valid_r;

  for (genvar g = 1; g <= N; g++) begin : g_cell
    rcpc_cell #(
      .SHIFT     (g),
      .SIG_SHIFTS(SIG_SHIFTS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(chain_v[g-1]),
      .d_i    (chain_d[g-1]),
      .valid_o(chain_v[g]),
      .d_o    (chain_d[g])
    );
  end

  assign last_d = chain_d[N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= chain_v[N];
    end
  end

  always_ff @(posedge clk) begin
    out_compatible_r      <= (last_d.sig_l == last_d.sig_r);
    out_canonical_left_r  <= last_d.best_l;
    out_canonical_right_r <= last_d.best_r;
    out_folded_left_r     <= last_d.fbest_l;
    out_folded_right_r    <= last_d.fbest_r;
    out_left_ones_r       <= last_d.weight;
    out_left_signature_r  <= last_d.sig_l;
    out_right_signature_r <= last_d.sig_r;
  end

  assign out_strobe          = out_strobe_r;
  assign out_compatible      = out_compatible_r;
  assign out_canonical_left  = out_canonical_left_r;
  assign out_canonical_right = out_canonical_right_r;
  assign out_folded_left     = out_folded_left_r;
  assign out_folded_right    = out_folded_right_r;
  assign out_left_ones       = out_left_ones_r;
  assign out_left_signature  = out_left_signature_r;
  assign out_right_signature = out_right_signature_r;

`ifndef NO_ASSERTIONS
  a_item_emerges: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(rcpc_pkg::LATENCY) out_strobe)
    else $error("accepted item did not produce a result");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, rcpc_pkg::LATENCY))
    else $error("result without a matching accepted item");

  a_compat_sig: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_compatible == (out_left_signature == out_right_signature)))
    else $error("compatible flag disagrees with signatures");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_left_ones <= 5'(rcpc_pkg::WORD_BITS)))
    else $error("weight out of range");
`endif

endmodule
`default_nettype wire
